// ===== rtl/tlpd_pkg.sv =====
// Shared types, constants and build-time functions for the tricolour lamp driver.
// Holds the colour codes, the red-lamp source select and the breathing-curve generator.
// No dependencies.
package tlpd_pkg;

  localparam int COLOUR_W = 3;
  localparam int PHASE_W  = 11;
  localparam int DUTY_W   = 8;

  localparam logic [COLOUR_W-1:0] COL_OFF     = 3'd0;
  localparam logic [COLOUR_W-1:0] COL_GREEN   = 3'd1;
  localparam logic [COLOUR_W-1:0] COL_YELLOW  = 3'd2;
  localparam logic [COLOUR_W-1:0] COL_RED     = 3'd3;
  localparam logic [COLOUR_W-1:0] COL_BREATHE = 3'd4;
  localparam logic [COLOUR_W-1:0] COL_FLASH   = 3'd5;

  localparam logic MODE_TICK    = 1'b0;
  localparam logic MODE_COMMAND = 1'b1;

  localparam logic [PHASE_W-1:0] PULSE_PERIOD    = 11'd1200;
  localparam logic [PHASE_W-1:0] FLASH_RESET     = 11'd500;
  localparam logic [PHASE_W-1:0] FLASH_MIN       = 11'd2;
  localparam logic [DUTY_W-1:0]  DUTY_FULL       = 8'd255;
  localparam logic [DUTY_W-1:0]  DUTY_ZERO       = 8'd0;

  // The curve is symmetric about half the period, so only the first half is stored.
  localparam int BREATHE_ROM_DEPTH = int'(PULSE_PERIOD) / 2 + 1;
  localparam int BREATHE_ADDR_W    = $clog2(BREATHE_ROM_DEPTH);

  typedef enum logic [1:0] {
    RED_HOLD,
    RED_CURVE,
    RED_FULL,
    RED_BLANK
  } red_sel_t;

  // Lamp update produced for one transfer, resolved one stage later.
  typedef struct packed {
    logic     green;
    logic     yellow;
    red_sel_t red_sel;
  } lamp_cmd_t;

  typedef logic [DUTY_W-1:0] duty_rom_t [0:BREATHE_ROM_DEPTH-1];

  localparam logic [63:0] ONE_Q31 = 64'h0000_0000_8000_0000;
  localparam logic [63:0] PI_Q60  = 64'h3243_F6A8_885A_308D;

  // Taylor-series divisors (2k-1)(2k) for k = 1..9.
  localparam logic [63:0] COS_DIV [0:8] = '{64'd2, 64'd12, 64'd30, 64'd56, 64'd90,
                                            64'd132, 64'd182, 64'd240, 64'd306};

  // cos(pi*n/PULSE_PERIOD) in Q31, truncating series, clamped to one.
  function automatic logic [63:0] cos_q31(input logic [63:0] n);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    x    = (((PI_Q60 >> 20) * n) / 64'(PULSE_PERIOD)) >> 9;
    x2   = (x * x) >> 31;
    term = ONE_Q31;
    sum  = ONE_Q31;
    for (int k = 0; k < 9; k++) begin
      term = ((term * x2) >> 31) / COS_DIV[k];
      if ((k % 2) == 0) begin
        sum = (sum > term) ? sum - term : 64'd0;
      end else begin
        sum = sum + term;
      end
    end
    return (sum > ONE_Q31) ? ONE_Q31 : sum;
  endfunction

  // Duty for a folded phase m, where m is the distance to the nearest period end.
  function automatic logic [DUTY_W-1:0] breathe_duty(input logic [63:0] m);
    logic [63:0] p;
    logic [63:0] t;
    logic        neg;
    logic [63:0] n;
    logic [63:0] c;
    logic [63:0] v;
    logic [63:0] prod;
    p    = 64'(PULSE_PERIOD);
    t    = 2 * m;
    neg  = (2 * t) > p;
    n    = neg ? p - t : t;
    c    = cos_q31(n);
    v    = neg ? ONE_Q31 + c : ONE_Q31 - c;
    prod = (64'd255 * v) >> 32;
    return prod[DUTY_W-1:0];
  endfunction

  function automatic duty_rom_t build_breathe_rom();
    duty_rom_t rom;
    for (int i = 0; i < BREATHE_ROM_DEPTH; i++) begin
      rom[i] = breathe_duty(64'(i));
    end
    return rom;
  endfunction

endpackage

// ===== rtl/tlpd_breathe_rom.sv =====
// Breathing-curve ROM with a registered read port.
// Depends on tlpd_pkg for the depth, widths and the build-time curve generator.
module tlpd_breathe_rom
  import tlpd_pkg::*;
(
  input  logic                      clk,
  input  logic                      en,
  input  logic [BREATHE_ADDR_W-1:0] addr,
  output logic [DUTY_W-1:0]         data
);

  localparam duty_rom_t CURVE = build_breathe_rom();

  always_ff @(posedge clk) begin
    if (en) begin
      data <= CURVE[addr];
    end
  end

endmodule

// ===== rtl/tlpd_control.sv =====
// Lamp state machine: active colour, phase counter, green and yellow levels, flash period.
// Depends on tlpd_pkg for colour codes and the lamp command struct.
module tlpd_control
  import tlpd_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [PHASE_W-1:0]        cfg_wdata,
  input  logic                      load,
  input  logic                      mode,
  input  logic [COLOUR_W-1:0]       colour,
  output lamp_cmd_t                 cmd,
  output logic [BREATHE_ADDR_W-1:0] curve_addr
);

  logic [COLOUR_W-1:0] active_colour;
  logic [COLOUR_W-1:0] active_colour_next;
  logic [PHASE_W-1:0]  phase_count;
  logic [PHASE_W-1:0]  phase_count_next;
  logic                green_level;
  logic                yellow_level;
  logic [PHASE_W-1:0]  flash_period;

  logic [PHASE_W-1:0]  flash_len;
  logic [PHASE_W:0]    phase_inc;
  logic [PHASE_W-1:0]  phase_breathe;
  logic [PHASE_W-1:0]  phase_flash;
  logic [PHASE_W-1:0]  phase_mirror;
  logic [PHASE_W-1:0]  phase_fold;
  logic                animated;

  assign flash_len = (flash_period < FLASH_MIN) ? FLASH_MIN : flash_period;
  assign phase_inc = {1'b0, phase_count} + 1'b1;

  // A phase at or past the period also wraps, since its increment is past it too.
  assign phase_breathe = (phase_inc >= {1'b0, PULSE_PERIOD}) ? '0 : phase_inc[PHASE_W-1:0];
  assign phase_flash   = (phase_inc >= {1'b0, flash_len}) ? '0 : phase_inc[PHASE_W-1:0];

  assign phase_mirror = PULSE_PERIOD - phase_breathe;
  assign phase_fold   = (phase_breathe < phase_mirror) ? phase_breathe : phase_mirror;
  assign curve_addr   = phase_fold[BREATHE_ADDR_W-1:0];

  assign animated = (colour == COL_BREATHE) || (colour == COL_FLASH);

  always_comb begin
    active_colour_next = active_colour;
    phase_count_next   = phase_count;
    cmd.green          = green_level;
    cmd.yellow         = yellow_level;
    cmd.red_sel        = RED_HOLD;
    if (mode == MODE_COMMAND) begin
      if (!(animated && (colour == active_colour))) begin
        active_colour_next = colour;
        unique case (colour)
          COL_GREEN: begin
            cmd.green   = 1'b1;
            cmd.yellow  = 1'b0;
            cmd.red_sel = RED_BLANK;
          end
          COL_YELLOW: begin
            cmd.green   = 1'b0;
            cmd.yellow  = 1'b1;
            cmd.red_sel = RED_BLANK;
          end
          COL_RED: begin
            cmd.green   = 1'b0;
            cmd.yellow  = 1'b0;
            cmd.red_sel = RED_FULL;
          end
          COL_BREATHE: begin
            cmd.green        = 1'b0;
            cmd.yellow       = 1'b0;
            phase_count_next = '0;
          end
          COL_FLASH: begin
            cmd.yellow       = 1'b0;
            cmd.red_sel      = RED_BLANK;
            phase_count_next = '0;
          end
          default: begin
            cmd.green   = 1'b0;
            cmd.yellow  = 1'b0;
            cmd.red_sel = RED_BLANK;
          end
        endcase
      end
    end else if (active_colour == COL_BREATHE) begin
      phase_count_next = phase_breathe;
      cmd.red_sel      = RED_CURVE;
    end else if (active_colour == COL_FLASH) begin
      phase_count_next = phase_flash;
      cmd.green        = phase_flash < (flash_len >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_colour <= COL_RED;
      phase_count   <= '0;
      green_level   <= 1'b0;
      yellow_level  <= 1'b0;
      flash_period  <= FLASH_RESET;
    end else begin
      if (cfg_we) begin
        flash_period <= cfg_wdata;
      end
      if (load) begin
        active_colour <= active_colour_next;
        phase_count   <= phase_count_next;
        green_level   <= cmd.green;
        yellow_level  <= cmd.yellow;
      end
    end
  end

endmodule

// ===== rtl/tricolour_led_pattern_driver.sv =====
// Top level of the tricolour lamp pattern driver.
// Depends on tlpd_pkg, tlpd_control and tlpd_breathe_rom.
//
// Usage. Each input transfer carries mode and colour: mode low is a one-millisecond
// tick, mode high a colour command (off, green, yellow, red, breathing red, flashing
// green; the two spare codes mean off). Every input transfer yields exactly one output
// transfer with the lamp levels after it: green_on, yellow_on and the red PWM duty.
// Both channels use valid and stall; a transfer happens when valid is high and stall
// is low. The flash period in ticks is written through cfg_we and cfg_wdata, by the
// user only while the block is idle; the block itself does not enforce this.
//
// The result of an input transfer passes through the middle stage, captured together
// with the registered read of the breathing-curve ROM, and then the output register.
// Throughput is one transfer per cycle while the receiver does not stall. When the
// receiver stalls, one further transfer is taken into the middle stage and in_stall
// then rises until the output moves on.
//
// After reset the lamp state is solid red (held red level 255, green and yellow off),
// the flash period is 500 ticks and no result is pending; the lamp outputs are not reset.
module tricolour_led_pattern_driver
  import tlpd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [PHASE_W-1:0]  cfg_wdata,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                mode,
  input  logic [COLOUR_W-1:0] colour,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                green_on,
  output logic                yellow_on,
  output logic [DUTY_W-1:0]   red_duty
);

  logic                      in_take;
  logic                      out_free;
  logic                      mid_move;
  lamp_cmd_t                 cmd;
  logic [BREATHE_ADDR_W-1:0] curve_addr;
  logic [DUTY_W-1:0]         curve_duty;

  // Middle stage: the lamp command waits here while the ROM read completes.
  logic                      mid_valid;
  lamp_cmd_t                 mid_cmd;

  // Red level after the last item that left the middle stage.
  logic [DUTY_W-1:0]         red_level;
  logic [DUTY_W-1:0]         red_resolved;

  assign out_free = !out_valid || !out_stall;
  assign mid_move = mid_valid && out_free;
  assign in_stall = mid_valid && !out_free;
  assign in_take  = in_valid && !in_stall;

  tlpd_control u_control (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .load       (in_take),
    .mode       (mode),
    .colour     (colour),
    .cmd        (cmd),
    .curve_addr (curve_addr)
  );

  // The ROM read is enabled only on an input transfer, so its data holds while the
  // middle stage waits for the output.
  tlpd_breathe_rom u_rom (
    .clk  (clk),
    .en   (in_take),
    .addr (curve_addr),
    .data (curve_duty)
  );

  always_comb begin
    unique case (mid_cmd.red_sel)
      RED_HOLD:  red_resolved = red_level;
      RED_CURVE: red_resolved = curve_duty;
      RED_FULL:  red_resolved = DUTY_FULL;
      RED_BLANK: red_resolved = DUTY_ZERO;
      default:   red_resolved = red_level;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
    end else if (in_take) begin
      mid_valid <= 1'b1;
    end else if (mid_move) begin
      mid_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      mid_cmd <= cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      red_level <= DUTY_FULL;
    end else if (mid_move) begin
      out_valid <= 1'b1;
      red_level <= red_resolved;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mid_move) begin
      green_on  <= mid_cmd.green;
      yellow_on <= mid_cmd.yellow;
      red_duty  <= red_resolved;
    end
  end

  // The input is held off only while both later stages are full and stalled.
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (mid_valid && out_valid && out_stall))
    else $error("input stalled while a stage was free");

  // An item leaving the middle stage always shows up on the output next cycle.
  a_mid_reaches_out: assert property (@(posedge clk) disable iff (rst)
    mid_move |=> out_valid)
    else $error("middle-stage item lost");

  // Yellow is only ever lit alone.
  a_yellow_alone: assert property (@(posedge clk) disable iff (rst)
    (out_valid && yellow_on) |-> (!green_on && (red_duty == DUTY_ZERO)))
    else $error("yellow lit together with another lamp");

  // Green, solid or flashing, never shares with yellow or red.
  a_green_alone: assert property (@(posedge clk) disable iff (rst)
    (out_valid && green_on) |-> (!yellow_on && (red_duty == DUTY_ZERO)))
    else $error("green lit together with another lamp");

endmodule
